/* rtl/nmp_pkg.sv */
// Package for the MIDI note pairing table: field widths, message and result
// codes, the command passed from front to back, and the sequencer states.
// No dependencies.
package nmp_pkg;

  // Field widths of the request and result items.
  localparam int KIND_W   = 2;
  localparam int CHAN_W   = 4;
  localparam int PITCH_W  = 7;
  localparam int VEL_W    = 7;
  localparam int TS_W     = 32;
  localparam int STATUS_W = 2;
  localparam int DFLT_W   = 16;

  // Pitches per channel; the table key is channel * 128 + pitch.
  localparam int PITCH_SPAN = 128;

  // One pending entry holds velocity and note-on time.
  localparam int PEND_W = VEL_W + TS_W;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ON    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAIN = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_PAIRED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_HUNG   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;

  // Reset value of the default duration register.
  localparam logic [DFLT_W-1:0] DFLT_DUR_RST = 16'd480;

  // Operations that survive classification.
  typedef enum logic [1:0] {
    OP_ON,
    OP_OFF,
    OP_DRAIN
  } cmd_op_t;

  // Command held in the queue between front and back.
  typedef struct packed {
    cmd_op_t              op;
    logic [CHAN_W-1:0]    chan;
    logic [PITCH_W-1:0]   pitch;
    logic [VEL_W-1:0]     vel;
    logic [TS_W-1:0]      ts;
  } cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_SCAN1,
    SEQ_SCAN2,
    SEQ_DROW,
    SEQ_DEMIT
  } seq_state_t;

endpackage

/* rtl/nmp_if.sv */
// Valid/ready channel interfaces for the note pairing table: the request
// channel and the result channel. Depends on nmp_pkg for field widths.
interface nmp_in_if;
  logic                          valid;
  logic                          ready;
  logic [nmp_pkg::KIND_W-1:0]    kind;
  logic [nmp_pkg::CHAN_W-1:0]    channel;
  logic [nmp_pkg::PITCH_W-1:0]   pitch;
  logic [nmp_pkg::VEL_W-1:0]     velocity;
  logic [nmp_pkg::TS_W-1:0]      timestamp;

  modport source (output valid, kind, channel, pitch, velocity, timestamp, input ready);
  modport sink   (input valid, kind, channel, pitch, velocity, timestamp, output ready);
endinterface

interface nmp_out_if;
  logic                          valid;
  logic                          ready;
  logic [nmp_pkg::STATUS_W-1:0]  status;
  logic [nmp_pkg::PITCH_W-1:0]   note_pitch;
  logic [nmp_pkg::VEL_W-1:0]     note_velocity;
  logic [nmp_pkg::TS_W-1:0]      start_tick;
  logic [nmp_pkg::TS_W-1:0]      duration_ticks;
  logic [nmp_pkg::CHAN_W-1:0]    note_channel;

  modport source (output valid, status, note_pitch, note_velocity, start_tick,
                  duration_ticks, note_channel, input ready);
  modport sink   (input valid, status, note_pitch, note_velocity, start_tick,
                  duration_ticks, note_channel, output ready);
endinterface

/* rtl/nmp_front.sv */
// Front end of the note pairing table: accepts requests and classifies them,
// dropping those that can never give a result. Depends on nmp_pkg, nmp_if.
module nmp_front #(
  parameter int CHANNELS = 16
) (
  nmp_in_if.sink              in_req,
  input  nmp_pkg::fifo_stat_t fifo_stat,
  output logic                cmd_push,
  output nmp_pkg::cmd_t       cmd_new
);
  import nmp_pkg::*;

  localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(CHANNELS);

  logic    chan_ok;
  logic    keep;
  cmd_op_t op;

  // A request is taken whenever the queue has room.
  assign in_req.ready = !fifo_stat.full;
  assign chan_ok      = {1'b0, in_req.channel} < CH_LIMIT;

  // Classify: note messages on a missing channel and unused kinds are dropped.
  always_comb begin
    keep = 1'b0;
    op   = OP_ON;
    case (in_req.kind)
      KIND_ON: begin
        keep = chan_ok;
        op   = OP_ON;
      end
      KIND_OFF: begin
        keep = chan_ok;
        op   = OP_OFF;
      end
      KIND_DRAIN: begin
        keep = 1'b1;
        op   = OP_DRAIN;
      end
      default: begin
        keep = 1'b0;
        op   = OP_ON;
      end
    endcase
  end

  assign cmd_push      = in_req.valid && in_req.ready && keep;
  assign cmd_new.op    = op;
  assign cmd_new.chan  = in_req.channel;
  assign cmd_new.pitch = in_req.pitch;
  assign cmd_new.vel   = in_req.velocity;
  assign cmd_new.ts    = in_req.timestamp;

endmodule

/* rtl/nmp_cmd_fifo.sv */
// Two-entry command queue between the front and back ends of the note
// pairing table. Depends on nmp_pkg.
module nmp_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nmp_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output nmp_pkg::cmd_t       head_cmd,
  output nmp_pkg::fifo_stat_t stat
);
  import nmp_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign head_cmd   = ent_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/nmp_back.sv */
// Back end of the note pairing table: holds the active-flag and pending-note
// memories, runs the sequencer and drives the result register.
// Depends on nmp_pkg and nmp_if.
module nmp_back #(
  parameter int CHANNELS  = 16,
  parameter int TICK_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nmp_pkg::cmd_t               head_cmd,
  input  nmp_pkg::fifo_stat_t         fifo_stat,
  output logic                        cmd_pop,
  input  logic [nmp_pkg::DFLT_W-1:0]  dflt_dur,
  nmp_out_if.source                   out_res
);
  import nmp_pkg::*;

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KEY_W    = CH_W + PITCH_W;
  localparam int ROW_W    = KEY_W - 4;
  localparam int ROWS     = 2 ** ROW_W;
  localparam int KEYS     = 2 ** KEY_W;
  localparam int DUR_BITS = (TICK_BITS < TS_W) ? TICK_BITS : TS_W;
  localparam int NZ_PAD   = 128;
  localparam int GRPS     = 8;

  // Lowest set bit of a 16-bit row.
  function automatic logic [3:0] first16(input logic [15:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  // Lowest set bit of the eight group flags.
  function automatic logic [2:0] first8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // Memories: 16 active flags per row, and one pending entry per key.
  logic [15:0]       flag_mem [ROWS];
  logic [PEND_W-1:0] pend_mem [KEYS];
  logic [15:0]       flag_rd_r;
  logic [PEND_W-1:0] pend_rd_r;

  // A row whose nonzero bit is clear reads as all zero, so these also reset the flags.
  logic [ROWS-1:0]   nz_r;

  seq_state_t        seq_r, seq_nxt;
  cmd_t              cmd_r;
  logic [GRPS-1:0]   grp_any_r;
  logic [3:0]        grp_first_r [GRPS];
  logic [ROW_W-1:0]  drow_r;
  logic [KEY_W-1:0]  dkey_r;

  logic              out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0] res_status_r;
  logic [PITCH_W-1:0]  res_pitch_r;
  logic [VEL_W-1:0]    res_vel_r;
  logic [TS_W-1:0]     res_start_r;
  logic [TS_W-1:0]     res_dur_r;
  logic [CHAN_W-1:0]   res_chan_r;

  // Sequencer outputs.
  logic              flag_re, flag_we, pend_re, pend_we;
  logic [ROW_W-1:0]  flag_ra, flag_wa;
  logic [15:0]       flag_wd;
  logic [KEY_W-1:0]  pend_ra;
  logic [PEND_W-1:0] pend_wd;
  logic              cmd_ld, scan_ld, drow_ld, dkey_ld, emit;
  logic [STATUS_W-1:0] res_status;
  logic [PITCH_W-1:0]  res_pitch;
  logic [VEL_W-1:0]    res_vel;
  logic [TS_W-1:0]     res_start;
  logic [TS_W-1:0]     res_dur;
  logic [CHAN_W-1:0]   res_chan;

  // Derived values.
  logic [KEY_W-1:0]  head_key, cmd_key, scan_key;
  logic [ROW_W-1:0]  cmd_row, scan_row;
  logic [15:0]       cmd_row_bits, cmd_row_set, cmd_row_clr, drain_row_clr;
  logic              cmd_hit, out_free, scan_found;
  logic [NZ_PAD-1:0] nz_pad;
  logic [GRPS-1:0]   grp_any;
  logic [3:0]        grp_first [GRPS];
  logic [2:0]        scan_grp;
  logic [6:0]        scan_row_full;
  logic [VEL_W-1:0]  pend_vel;
  logic [TS_W-1:0]   pend_on;
  logic [TS_W-1:0]   diff;
  logic [TS_W-1:0]   pair_dur;

  assign head_key     = {head_cmd.chan[CH_W-1:0], head_cmd.pitch};
  assign cmd_key      = {cmd_r.chan[CH_W-1:0], cmd_r.pitch};
  assign cmd_row      = cmd_key[KEY_W-1:4];
  assign cmd_row_bits = nz_r[cmd_row] ? flag_rd_r : 16'd0;
  assign cmd_hit      = cmd_row_bits[cmd_r.pitch[3:0]];
  assign cmd_row_set  = cmd_row_bits | (16'd1 << cmd_r.pitch[3:0]);
  assign cmd_row_clr  = cmd_row_bits & ~(16'd1 << cmd_r.pitch[3:0]);
  assign drain_row_clr = flag_rd_r & ~(16'd1 << dkey_r[3:0]);
  assign out_free     = !out_vld_r || out_res.ready;

  assign pend_vel = pend_rd_r[PEND_W-1:TS_W];
  assign pend_on  = pend_rd_r[TS_W-1:0];
  assign diff     = cmd_r.ts - pend_on;
  assign pair_dur = TS_W'(diff[DUR_BITS-1:0]);

  // First stage of the drain search: per group of 16 rows, any set and first set.
  assign nz_pad = NZ_PAD'(nz_r);
  always_comb begin
    for (int g = 0; g < GRPS; g++) begin
      grp_any[g]   = |nz_pad[g*16 +: 16];
      grp_first[g] = first16(nz_pad[g*16 +: 16]);
    end
  end

  // Second stage: pick the first group, then the row and bit within it.
  assign scan_found    = |grp_any_r;
  assign scan_grp      = first8(grp_any_r);
  assign scan_row_full = {scan_grp, grp_first_r[scan_grp]};
  assign scan_row      = scan_row_full[ROW_W-1:0];
  assign scan_key      = {drow_r, first16(flag_rd_r)};

  // Next state.
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      SEQ_IDLE: begin
        if (!fifo_stat.empty) begin
          seq_nxt = (head_cmd.op == OP_DRAIN) ? SEQ_SCAN1 : SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        if (cmd_r.op != OP_OFF || !cmd_hit || out_free) begin
          seq_nxt = SEQ_IDLE;
        end
      end
      SEQ_SCAN1: seq_nxt = SEQ_SCAN2;
      SEQ_SCAN2: begin
        if (scan_found) begin
          seq_nxt = SEQ_DROW;
        end else if (out_free) begin
          seq_nxt = SEQ_IDLE;
        end
      end
      SEQ_DROW:  seq_nxt = SEQ_DEMIT;
      SEQ_DEMIT: begin
        if (out_free) begin
          seq_nxt = SEQ_IDLE;
        end
      end
      default:   seq_nxt = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: memory accesses, loads and the result.
  always_comb begin
    cmd_pop    = 1'b0;
    cmd_ld     = 1'b0;
    scan_ld    = 1'b0;
    drow_ld    = 1'b0;
    dkey_ld    = 1'b0;
    flag_re    = 1'b0;
    flag_ra    = head_key[KEY_W-1:4];
    pend_re    = 1'b0;
    pend_ra    = head_key;
    flag_we    = 1'b0;
    flag_wa    = cmd_row;
    flag_wd    = cmd_row_set;
    pend_we    = 1'b0;
    pend_wd    = {cmd_r.vel, cmd_r.ts};
    emit       = 1'b0;
    res_status = STAT_PAIRED;
    res_pitch  = cmd_r.pitch;
    res_vel    = pend_vel;
    res_start  = pend_on;
    res_dur    = pair_dur;
    res_chan   = cmd_r.chan;
    case (seq_r)
      SEQ_IDLE: begin
        if (!fifo_stat.empty) begin
          cmd_pop = 1'b1;
          cmd_ld  = 1'b1;
          flag_re = 1'b1;
          pend_re = 1'b1;
        end
      end
      SEQ_EXEC: begin
        if (cmd_r.op == OP_ON) begin
          pend_we = 1'b1;
          flag_we = 1'b1;
        end else if (cmd_hit && out_free) begin
          flag_we = 1'b1;
          flag_wd = cmd_row_clr;
          emit    = 1'b1;
        end
      end
      SEQ_SCAN1: scan_ld = 1'b1;
      SEQ_SCAN2: begin
        if (scan_found) begin
          drow_ld = 1'b1;
          flag_re = 1'b1;
          flag_ra = scan_row;
        end else if (out_free) begin
          emit       = 1'b1;
          res_status = STAT_EMPTY;
          res_pitch  = '0;
          res_vel    = '0;
          res_start  = '0;
          res_dur    = '0;
          res_chan   = '0;
        end
      end
      SEQ_DROW: begin
        dkey_ld = 1'b1;
        pend_re = 1'b1;
        pend_ra = scan_key;
      end
      SEQ_DEMIT: begin
        if (out_free) begin
          flag_we    = 1'b1;
          flag_wa    = drow_r;
          flag_wd    = drain_row_clr;
          emit       = 1'b1;
          res_status = STAT_HUNG;
          res_pitch  = dkey_r[PITCH_W-1:0];
          res_dur    = TS_W'(dflt_dur);
          res_chan   = CHAN_W'(dkey_r[KEY_W-1:PITCH_W]);
        end
      end
      default: ;
    endcase
  end

  // Result register: holds until taken, and refills in the cycle it is taken.
  always_comb begin
    out_vld_nxt = out_vld_r && !out_res.ready;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= SEQ_IDLE;
      out_vld_r <= 1'b0;
      nz_r      <= '0;
    end else begin
      seq_r     <= seq_nxt;
      out_vld_r <= out_vld_nxt;
      if (flag_we) begin
        nz_r[flag_wa] <= (flag_wd != 16'd0);
      end
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    if (cmd_ld) begin
      cmd_r <= head_cmd;
    end
    if (scan_ld) begin
      grp_any_r   <= grp_any;
      grp_first_r <= grp_first;
    end
    if (drow_ld) begin
      drow_r <= scan_row;
    end
    if (dkey_ld) begin
      dkey_r <= scan_key;
    end
    if (emit) begin
      res_status_r <= res_status;
      res_pitch_r  <= res_pitch;
      res_vel_r    <= res_vel;
      res_start_r  <= res_start;
      res_dur_r    <= res_dur;
      res_chan_r   <= res_chan;
    end
  end

  // Active-flag memory, registered read.
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
    if (flag_re) begin
      flag_rd_r <= flag_mem[flag_ra];
    end
  end

  // Pending-note memory, registered read.
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[cmd_key] <= pend_wd;
    end
    if (pend_re) begin
      pend_rd_r <= pend_mem[pend_ra];
    end
  end

  assign out_res.valid          = out_vld_r;
  assign out_res.status         = res_status_r;
  assign out_res.note_pitch     = res_pitch_r;
  assign out_res.note_velocity  = res_vel_r;
  assign out_res.start_tick     = res_start_r;
  assign out_res.duration_ticks = res_dur_r;
  assign out_res.note_channel   = res_chan_r;

endmodule

/* rtl/midi_note_pairing_table.sv */
// MIDI note pairing table: front end, command queue and back end.
// Each command is popped in the idle state. Note-on and note-off then pass the
// execute state, while a drain goes through a two-stage row search, a flag-row
// read and an entry read, and ends after the row search on an empty table. The
// back end takes a new command only after it is done with the last one.
// Reset (rst_n, synchronous) clears all flags at once; no clearing pass is needed.
module midi_note_pairing_table #(
  parameter int CHANNELS  = 16,
  parameter int TICK_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  nmp_in_if.sink                      in_req,
  nmp_out_if.source                   out_res,
  input  logic                        cfg_we,
  input  logic [nmp_pkg::DFLT_W-1:0]  cfg_wdata
);
  import nmp_pkg::*;

  logic              cmd_push;
  logic              cmd_pop;
  cmd_t              cmd_new;
  cmd_t              head_cmd;
  fifo_stat_t        fifo_stat;
  logic [DFLT_W-1:0] dflt_dur_r;

  // Default duration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_dur_r <= DFLT_DUR_RST;
    end else if (cfg_we) begin
      dflt_dur_r <= cfg_wdata;
    end
  end

  nmp_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .in_req    (in_req),
    .fifo_stat (fifo_stat),
    .cmd_push  (cmd_push),
    .cmd_new   (cmd_new)
  );

  nmp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_new),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .stat     (fifo_stat)
  );

  nmp_back #(
    .CHANNELS  (CHANNELS),
    .TICK_BITS (TICK_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .fifo_stat (fifo_stat),
    .cmd_pop   (cmd_pop),
    .dflt_dur  (dflt_dur_r),
    .out_res   (out_res)
  );

`ifndef ASSERT_OFF
  // The front must never write a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !fifo_stat.full)
    else $error("command pushed into a full queue");

  // The back must never take a command from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !fifo_stat.empty)
    else $error("command popped from an empty queue");

  // No result is offered straight after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_res.valid)
    else $error("result offered straight after reset");
`endif

endmodule

/* tb/tb_midi_note_pairing_table.sv */
`timescale 1ns / 1ps
// Testbench for midi_note_pairing_table: directed and random note requests checked
// against a behavioural copy of the pairing table. Depends on nmp_pkg, the
// nmp_in_if and nmp_out_if interfaces and the midi_note_pairing_table RTL.
module tb_midi_note_pairing_table;
  import nmp_pkg::*;

  localparam int TB_CHANNELS = 16;
  localparam int KEY_W = CHAN_W + PITCH_W;
  localparam int TABLE_DEPTH = 1 << KEY_W;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_PCT = 12;
  localparam int QUIET_CYCLES = 16;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 250;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAN_W-1:0]  chan;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   vel;
    logic [TS_W-1:0]    ts;
  } note_msg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PITCH_W-1:0]  pitch;
    logic [VEL_W-1:0]    vel;
    logic [TS_W-1:0]     start;
    logic [TS_W-1:0]     dur;
    logic [CHAN_W-1:0]   chan;
  } note_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [DFLT_W-1:0] cfg_wdata;

  nmp_in_if  req_bus ();
  nmp_out_if res_bus ();

  midi_note_pairing_table #(
    .CHANNELS  (TB_CHANNELS),
    .TICK_BITS (TS_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_bus),
    .out_res   (res_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Our own copy of the table: flags, held velocity and note-on time per key.
  bit                note_held [TABLE_DEPTH];
  logic [VEL_W-1:0]  held_vel  [TABLE_DEPTH];
  logic [TS_W-1:0]   held_on   [TABLE_DEPTH];
  logic [DFLT_W-1:0] dflt_dur = DFLT_DUR_RST;

  // Notes the block still owes us, oldest first.
  note_result_t finished_notes_q [$];

  int err_count = 0;
  bit no_idle = 1'b0;
  logic [TS_W-1:0] tick_now = '0;
  logic [CHAN_W-1:0]  chan_pool  [4];
  logic [PITCH_W-1:0] pitch_pool [6];

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one accepted request to the table copy and queue any note it finishes.
  // Returns whether the request did anything at all.
  function automatic bit apply_to_table(input note_msg_t m);
    logic [KEY_W-1:0] key;
    note_result_t r;
    int k;
    key = {m.chan, m.pitch};
    r = '0;
    case (m.kind)
      KIND_ON: begin
        if (m.chan >= TB_CHANNELS) return 1'b0;
        held_vel[key] = m.vel;
        held_on[key] = m.ts;
        note_held[key] = 1'b1;
        return 1'b1;
      end
      KIND_OFF: begin
        if (m.chan >= TB_CHANNELS || !note_held[key]) return 1'b0;
        r.status = STAT_PAIRED;
        r.pitch = m.pitch;
        r.vel = held_vel[key];
        r.start = held_on[key];
        r.dur = m.ts - held_on[key];
        r.chan = m.chan;
        note_held[key] = 1'b0;
        finished_notes_q.insert(finished_notes_q.size(), r);
        return 1'b1;
      end
      KIND_DRAIN: begin
        // Lowest pending key wins; an empty table gives an all-zero empty result.
        r.status = STAT_EMPTY;
        for (k = 0; k < TABLE_DEPTH && r.status == STAT_EMPTY; k++) begin
          key = k[KEY_W-1:0];
          if (note_held[key]) begin
            r.status = STAT_HUNG;
            r.pitch = key[PITCH_W-1:0];
            r.vel = held_vel[key];
            r.start = held_on[key];
            r.dur = {{(TS_W-DFLT_W){1'b0}}, dflt_dur};
            r.chan = key[KEY_W-1:PITCH_W];
            note_held[key] = 1'b0;
          end
        end
        finished_notes_q.insert(finished_notes_q.size(), r);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic note_msg_t make_msg(input logic [KIND_W-1:0] kind,
                                         input logic [CHAN_W-1:0] chan,
                                         input logic [PITCH_W-1:0] pitch,
                                         input logic [VEL_W-1:0] vel,
                                         input logic [TS_W-1:0] ts);
    note_msg_t m;
    m.kind = kind;
    m.chan = chan;
    m.pitch = pitch;
    m.vel = vel;
    m.ts = ts;
    return m;
  endfunction

  // Present one request, with a random gap first, and hold it until accepted.
  task automatic send_request(input note_msg_t m);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.kind      <= m.kind;
    req_bus.channel   <= m.chan;
    req_bus.pitch     <= m.pitch;
    req_bus.velocity  <= m.vel;
    req_bus.timestamp <= m.ts;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    void'(apply_to_table(m));
  endtask

  // Stop sending, wait for every owed note, then give the block time to finish
  // any request that produces nothing.
  task automatic settle_table();
    req_bus.valid <= 1'b0;
    while (finished_notes_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_default(input logic [DFLT_W-1:0] val);
    settle_table();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    dflt_dur = val;
  endtask

  // Mostly well-formed traffic on a few keys so that notes pair up, plus noise.
  function automatic note_msg_t random_request();
    note_msg_t m;
    int pick;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) tick_now = $urandom();
    else tick_now = tick_now + $urandom_range(1, 3000);
    m = make_msg(KIND_ON, chan_pool[$urandom_range(3)], pitch_pool[$urandom_range(5)],
                 VEL_W'($urandom_range(127)), tick_now);
    if (pick < 40) begin
      m.kind = KIND_ON;
    end else if (pick < 78) begin
      m.kind = KIND_OFF;
    end else if (pick < 90) begin
      m.kind = KIND_DRAIN;
    end else begin
      m.kind = KIND_W'($urandom_range(3));
      m.chan = CHAN_W'($urandom_range(15));
      m.pitch = PITCH_W'($urandom_range(127));
      m.ts = $urandom();
    end
    return m;
  endfunction

  task automatic test_pairing_basics();
    // A drain on an empty table reports empty.
    send_request(make_msg(KIND_DRAIN, 4'd0, 7'd0, 7'd0, 32'd0));
    // Field extremes: lowest key at time zero, highest key across the tick wrap.
    send_request(make_msg(KIND_ON, 4'd0, 7'd0, 7'd0, 32'd0));
    send_request(make_msg(KIND_OFF, 4'd0, 7'd0, 7'd127, 32'd0));
    send_request(make_msg(KIND_ON, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF));
    send_request(make_msg(KIND_OFF, 4'd15, 7'd127, 7'd0, 32'd5));
    // A note-off with nothing pending, and the unused kind, are both ignored.
    send_request(make_msg(KIND_OFF, 4'd7, 7'd60, 7'd100, 32'd1000));
    send_request(make_msg(KIND_UNUSED, 4'd7, 7'd60, 7'd100, 32'd1000));
    send_request(make_msg(KIND_OFF, 4'd7, 7'd60, 7'd100, 32'd1100));
    // A repeated note-on replaces the earlier one.
    send_request(make_msg(KIND_ON, 4'd9, 7'd64, 7'd20, 32'd100));
    send_request(make_msg(KIND_ON, 4'd9, 7'd64, 7'd90, 32'd250));
    send_request(make_msg(KIND_OFF, 4'd9, 7'd64, 7'd0, 32'd400));
    // Note-off earlier than its note-on wraps the duration.
    send_request(make_msg(KIND_ON, 4'd2, 7'd10, 7'd55, 32'd100));
    send_request(make_msg(KIND_OFF, 4'd2, 7'd10, 7'd55, 32'd50));
    // Drains come out in ascending key order, then the table is empty.
    send_request(make_msg(KIND_ON, 4'd15, 7'd127, 7'd1, 32'h0000_1234));
    send_request(make_msg(KIND_ON, 4'd0, 7'd5, 7'd2, 32'h8000_0000));
    send_request(make_msg(KIND_ON, 4'd3, 7'd64, 7'd3, 32'h7FFF_FFFF));
    send_request(make_msg(KIND_ON, 4'd0, 7'd4, 7'd127, 32'hFFFF_FFFF));
    repeat (5) send_request(make_msg(KIND_DRAIN, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF));
  endtask

  task automatic test_default_duration();
    // A zero default is passed out unchanged.
    write_default(16'd0);
    send_request(make_msg(KIND_ON, 4'd1, 7'd1, 7'd11, 32'd77));
    send_request(make_msg(KIND_DRAIN, 4'd0, 7'd0, 7'd0, 32'd0));
    send_request(make_msg(KIND_DRAIN, 4'd0, 7'd0, 7'd0, 32'd0));
    write_default(16'hFFFF);
    send_request(make_msg(KIND_ON, 4'd8, 7'd100, 7'd64, 32'hDEAD_BEEF));
    send_request(make_msg(KIND_DRAIN, 4'd0, 7'd0, 7'd0, 32'd0));
    // The default must not leak into paired notes.
    write_default(16'd1);
    send_request(make_msg(KIND_ON, 4'd5, 7'd33, 7'd99, 32'd10));
    send_request(make_msg(KIND_OFF, 4'd5, 7'd33, 7'd0, 32'd20));
    send_request(make_msg(KIND_ON, 4'd5, 7'd34, 7'd98, 32'd30));
    send_request(make_msg(KIND_DRAIN, 4'd0, 7'd0, 7'd0, 32'd0));
    write_default(DFLT_DUR_RST);
  endtask

  task automatic test_random_traffic();
    int phase;
    int i;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_default(DFLT_W'($urandom_range(0, 65535)));
      // One phase runs with neither side ever idling.
      no_idle = (phase == 2);
      for (i = 0; i < 4; i++) chan_pool[i] = CHAN_W'($urandom_range(15));
      for (i = 0; i < 6; i++) pitch_pool[i] = PITCH_W'($urandom_range(127));
      for (i = 0; i < ITEMS_PER_PHASE; i++) send_request(random_request());
    end
    no_idle = 1'b0;
  endtask

  // Result side stalls at random.
  always @(posedge clk) res_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

  task automatic compare_field(input string name, input logic [TS_W-1:0] want_v,
                               input logic [TS_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      err_count++;
    end
  endtask

  // Compare every accepted result with the oldest owed note.
  always @(posedge clk) begin
    note_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (finished_notes_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d pitch %0d channel %0d", $time,
                 res_bus.status, res_bus.note_pitch, res_bus.note_channel);
        err_count++;
      end else begin
        want = finished_notes_q.pop_front();
        compare_field("status", TS_W'(want.status), TS_W'(res_bus.status));
        compare_field("note_pitch", TS_W'(want.pitch), TS_W'(res_bus.note_pitch));
        compare_field("note_velocity", TS_W'(want.vel), TS_W'(res_bus.note_velocity));
        compare_field("start_tick", want.start, res_bus.start_tick);
        compare_field("duration_ticks", want.dur, res_bus.duration_ticks);
        compare_field("note_channel", TS_W'(want.chan), TS_W'(res_bus.note_channel));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_bus.valid = 1'b0;
    req_bus.kind = '0;
    req_bus.channel = '0;
    req_bus.pitch = '0;
    req_bus.velocity = '0;
    req_bus.timestamp = '0;
    res_bus.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_pairing_basics();
    test_default_duration();
    test_random_traffic();
    settle_table();
    if (err_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
